/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the reorder buffer. They compile to nothing when
// SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising edge outside reset
`define SRB_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising edge outside reset
`define SRB_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	`SRB_ASSERT(label, clk, rst_n, !(cond), msg)

`else

`define SRB_ASSERT(label, clk, rst_n, prop, msg)
`define SRB_ASSERT_NEVER(label, clk, rst_n, cond, msg)

`endif

`endif

/* sv/srb_pkg.sv */
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types, codes and helpers of the sequence reorder buffer.
// ----------------------------------------------------------------------------
package srb_pkg;

	localparam int SRB_SLOTS       = 16;
	localparam int SRB_FRAME_WORDS = 33;
	localparam int WORD_W          = 64;

	// Request types on the input channel
	localparam logic REQ_PUSH = 1'b0;
	localparam logic REQ_POP  = 1'b1;

	// Register index of seq_window and its reset value
	localparam logic       IDX_SEQ_WINDOW   = 1'b0;
	localparam logic [7:0] SRB_WINDOW_RESET = 8'd64;

	// Result status codes
	typedef enum logic [1:0] {
		STAT_PUSH_OK   = 2'd0,
		STAT_PUSH_DROP = 2'd1,
		STAT_POP_EMPTY = 2'd2,
		STAT_POP_DATA  = 2'd3
	} status_t;

	// Pop sequencer states
	typedef enum logic [1:0] {
		S_IDLE,
		S_LEN,
		S_STREAM
	} state_t;

	// One result item
	typedef struct packed {
		status_t             status;
		logic [WORD_W-1:0]   word;
		logic [3:0]          bytes;
		logic                last;
		logic [7:0]          seq;
	} result_t;

	// Keep the low nb bytes of a word; eight or more keeps all
	function automatic logic [WORD_W-1:0] byte_mask(input logic [3:0] nb);
		logic [WORD_W-1:0] m;
		m = '0;
		for (int i = 0; i < 8; i++) begin
			m[8*i +: 8] = (4'(i) < nb) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

/* sv/srb_ram.sv */
// ----------------------------------------------------------------------------
// srb_ram
// Generic simple dual-port RAM: one write port and one read port with a
// registered read.
// ----------------------------------------------------------------------------
module srb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                       clk,
	input  logic                       we,
	input  logic [$clog2(DEPTH)-1:0]   waddr,
	input  logic [WIDTH-1:0]           wdata,
	input  logic                       re,
	input  logic [$clog2(DEPTH)-1:0]   raddr,
	output logic [WIDTH-1:0]           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

/* sv/srb_out_buf.sv */
// ----------------------------------------------------------------------------
// srb_out_buf
// Two-entry result queue between the core and the output channel.
// ----------------------------------------------------------------------------
module srb_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             enq_valid,
	input  srb_pkg::result_t enq_data,
	output logic             out_valid,
	input  logic             out_stall,
	output srb_pkg::result_t out_data,
	output logic [1:0]       count
);
	import srb_pkg::*;

	result_t    ent_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       take;

	assign take      = (count_q != 2'd0) && !out_stall;
	assign out_valid = (count_q != 2'd0);
	assign out_data  = ent_q[rd_ptr_q];
	assign count     = count_q;

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (enq_valid) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (take) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, enq_valid} - {1'b0, take};
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (enq_valid) begin
			ent_q[wr_ptr_q] <= enq_data;
		end
	end

endmodule

/* sv/sequence_reorder_buffer.sv */
// ----------------------------------------------------------------------------
// sequence_reorder_buffer
// Stores pushed packets in slots picked by sequence number and streams them
// out in sequence order on pop requests.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  input   | in        | in_valid/in_stall  | req_type seq data_word in_bytes in_last
//  output  | out       | out_valid/out_stall| status out_word out_bytes out_last out_seq
//  config  | in        | APB write/read     | seq_window at address 0
//
//  A push word is taken whenever the input is not stalled; the last word of a
//  push also queues its status result. A pop checks the slot valid bit, reads
//  the slot length in S_LEN, then reads one packet word per issue from the word
//  RAM in S_STREAM, and holds the input stalled until the last word has landed.
//  Reset clears all slot valid bits at once; no clearing pass is needed.
//  Output stalls back up through a two-entry result queue and stretch a pop run.
`include "assert_macros.svh"

module sequence_reorder_buffer #(
	parameter int SLOTS       = srb_pkg::SRB_SLOTS,
	parameter int FRAME_WORDS = srb_pkg::SRB_FRAME_WORDS
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [7:0]  seq,
	input  logic [63:0] data_word,
	input  logic [3:0]  in_bytes,
	input  logic        in_last,
	// output channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [63:0] out_word,
	output logic [3:0]  out_bytes,
	output logic        out_last,
	output logic [7:0]  out_seq,
	// configuration
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import srb_pkg::*;

	localparam int SW = $clog2(SLOTS);
	localparam int AW = $clog2(SLOTS * FRAME_WORDS);
	localparam int RW = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
	localparam int IW = $clog2(FRAME_WORDS + 1);
	localparam int LW = RW + 4;

	// Sequence number to slot, built at elaboration
	function automatic logic [256*SW-1:0] mod_table();
		logic [256*SW-1:0] t;
		t = '0;
		for (int i = 0; i < 256; i++) begin
			t[i*SW +: SW] = SW'(i % SLOTS);
		end
		return t;
	endfunction

	localparam logic [256*SW-1:0] SLOT_TBL = mod_table();

	// Registers
	logic [7:0]     seq_window_q;
	logic [SLOTS-1:0] slot_valid_q;
	logic [7:0]     expected_seq_q;
	logic           push_active_q;
	logic           push_dropping_q;
	logic [SW-1:0]  push_slot_q;
	logic [IW-1:0]  push_index_q;
	state_t         state_q, state_d;
	logic [AW-1:0]  pop_base_q;
	logic [7:0]     pop_seq_q;
	logic [RW-1:0]  last_idx_q;
	logic [3:0]     last_nb_q;
	logic [RW-1:0]  rd_idx_q;
	logic           inflight_s1;
	logic           rd_last_s1;

	// Combinational
	logic           in_acc;
	logic           push_acc;
	logic           pop_acc;
	logic           first;
	logic [7:0]     raw;
	logic [8:0]     mag;
	logic           drop_calc;
	logic           cur_drop;
	logic [SW-1:0]  cur_slot;
	logic [IW-1:0]  cur_idx;
	logic           in_frame;
	logic [3:0]     eff_nb;
	logic           word_we;
	logic           len_we;
	logic [LW-1:0]  len_wdata;
	logic [SW-1:0]  pop_slot;
	logic           pop_hit;
	logic           stat_enq;
	result_t        stat_res;
	logic           issue;
	logic           take;
	logic           enq_valid;
	result_t        enq_data;
	result_t        head;
	logic [1:0]     buf_count;
	logic [AW-1:0]  word_waddr;
	logic [AW-1:0]  word_raddr;
	logic [63:0]    word_rdata;
	logic [LW-1:0]  len_rdata;
	logic           cfg_wr;

	// Configuration port
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && (paddr[2] == IDX_SEQ_WINDOW);
	assign prdata = (paddr[2] == IDX_SEQ_WINDOW) ? {24'd0, seq_window_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_window_q <= SRB_WINDOW_RESET;
		end else if (cfg_wr) begin
			seq_window_q <= pwdata[7:0];
		end
	end

	// Input handshake
	assign in_stall = (state_q != S_IDLE) || inflight_s1 || (buf_count == 2'd2);
	assign in_acc   = in_valid && !in_stall;
	assign push_acc = in_acc && (req_type == REQ_PUSH);
	assign pop_acc  = in_acc && (req_type == REQ_POP);

	// Push: window check and slot selection on the first word
	always_comb begin
		first     = !push_active_q;
		raw       = seq - expected_seq_q;
		mag       = raw[7] ? (9'd256 - {1'b0, raw}) : {1'b0, raw};
		drop_calc = mag > {1'b0, seq_window_q};
		cur_drop  = first ? drop_calc : push_dropping_q;
		cur_slot  = first ? SLOT_TBL[seq*SW +: SW] : push_slot_q;
		cur_idx   = first ? '0 : push_index_q;
		in_frame  = cur_idx < IW'(FRAME_WORDS);
		if (in_last && (in_bytes inside {[4'd1:4'd8]})) begin
			eff_nb = in_bytes;
		end else begin
			eff_nb = 4'd8;
		end
		word_we    = push_acc && !cur_drop && in_frame;
		len_we     = push_acc && !cur_drop && in_last;
		word_waddr = AW'(cur_slot * FRAME_WORDS + cur_idx);
		if (in_frame) begin
			len_wdata = {cur_idx[RW-1:0], eff_nb};
		end else begin
			len_wdata = {RW'(FRAME_WORDS - 1), 4'd8};
		end
	end

	// Pop: check the expected slot
	assign pop_slot = SLOT_TBL[expected_seq_q*SW +: SW];
	assign pop_hit  = pop_acc && slot_valid_q[pop_slot];

	// Status result of a finished push or an empty pop
	always_comb begin
		stat_enq        = (push_acc && in_last) || (pop_acc && !pop_hit);
		stat_res.word   = '0;
		stat_res.bytes  = 4'd0;
		stat_res.last   = 1'b1;
		if (req_type == REQ_POP) begin
			stat_res.status = STAT_POP_EMPTY;
			stat_res.seq    = expected_seq_q;
		end else begin
			stat_res.status = cur_drop ? STAT_PUSH_DROP : STAT_PUSH_OK;
			stat_res.seq    = seq;
		end
	end

	// Push and slot state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_valid_q    <= '0;
			expected_seq_q  <= 8'd0;
			push_active_q   <= 1'b0;
			push_dropping_q <= 1'b0;
			push_slot_q     <= '0;
			push_index_q    <= '0;
		end else begin
			if (push_acc) begin
				if (first && !cur_drop) begin
					slot_valid_q[cur_slot] <= 1'b0;
				end
				if (in_last) begin
					if (!cur_drop) begin
						slot_valid_q[cur_slot] <= 1'b1;
					end
					push_active_q   <= 1'b0;
					push_dropping_q <= 1'b0;
				end else begin
					push_active_q   <= 1'b1;
					push_dropping_q <= cur_drop;
					push_slot_q     <= cur_slot;
					push_index_q    <= word_we ? cur_idx + IW'(1) : cur_idx;
				end
			end
			if (pop_hit) begin
				slot_valid_q[pop_slot] <= 1'b0;
				expected_seq_q         <= expected_seq_q + 8'd1;
			end
		end
	end

	// Read issue: room for the word when it lands next cycle
	assign take  = out_valid && !out_stall;
	assign issue = (state_q == S_STREAM) &&
		(({1'b0, buf_count} + {2'b00, inflight_s1}) <= (3'd1 + {2'b00, take}));
	assign word_raddr = AW'(pop_base_q + AW'(rd_idx_q));

	// Pop sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (pop_hit) begin
					state_d = S_LEN;
				end
			end
			S_LEN: begin
				state_d = S_STREAM;
			end
			S_STREAM: begin
				if (issue && (rd_idx_q == last_idx_q)) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			inflight_s1 <= 1'b0;
		end else begin
			state_q     <= state_d;
			inflight_s1 <= issue;
		end
	end

	// Pop run payload registers
	always_ff @(posedge clk) begin
		if (pop_hit) begin
			pop_seq_q  <= expected_seq_q;
			pop_base_q <= AW'(pop_slot * FRAME_WORDS);
		end
		if (state_q == S_LEN) begin
			last_idx_q <= len_rdata[LW-1:4];
			last_nb_q  <= len_rdata[3:0];
			rd_idx_q   <= '0;
		end else if (issue) begin
			rd_idx_q <= rd_idx_q + RW'(1);
		end
		rd_last_s1 <= (rd_idx_q == last_idx_q);
	end

	// Slot word store
	srb_ram #(
		.WIDTH (64),
		.DEPTH (SLOTS * FRAME_WORDS)
	) u_word_ram (
		.clk   (clk),
		.we    (word_we),
		.waddr (word_waddr),
		.wdata (data_word & byte_mask(eff_nb)),
		.re    (issue),
		.raddr (word_raddr),
		.rdata (word_rdata)
	);

	// Slot length store: last word index and its byte count
	srb_ram #(
		.WIDTH (LW),
		.DEPTH (SLOTS)
	) u_len_ram (
		.clk   (clk),
		.we    (len_we),
		.waddr (cur_slot),
		.wdata (len_wdata),
		.re    (pop_hit),
		.raddr (pop_slot),
		.rdata (len_rdata)
	);

	// Merge status results and popped words into the queue
	always_comb begin
		enq_valid = stat_enq || inflight_s1;
		if (inflight_s1) begin
			enq_data.status = STAT_POP_DATA;
			enq_data.word   = word_rdata;
			enq_data.bytes  = rd_last_s1 ? last_nb_q : 4'd8;
			enq_data.last   = rd_last_s1;
			enq_data.seq    = pop_seq_q;
		end else begin
			enq_data = stat_res;
		end
	end

	srb_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.enq_valid (enq_valid),
		.enq_data  (enq_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (head),
		.count     (buf_count)
	);

	assign status    = head.status;
	assign out_word  = head.word;
	assign out_bytes = head.bytes;
	assign out_last  = head.last;
	assign out_seq   = head.seq;

	// Checks
	`SRB_ASSERT_NEVER(a_enq_full, clk, arst_n, enq_valid && (buf_count == 2'd2) && !take, "result queue overflow")
	`SRB_ASSERT_NEVER(a_enq_clash, clk, arst_n, inflight_s1 && stat_enq, "status and pop word collide")
	`SRB_ASSERT(a_pop_len, clk, arst_n, pop_hit |=> (state_q == S_LEN), "pop hit did not read length")
	`SRB_ASSERT(a_exp_adv, clk, arst_n, (expected_seq_q != $past(expected_seq_q)) |-> $past(pop_hit), "expected sequence moved without pop")

endmodule

/* tb/sequence_reorder_buffer_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_test
// Pushes packets and pop requests into the reorder buffer with random idle and
// stall on both channels. A behavioral copy of the slot store predicts every
// result, and each output transfer is compared field by field in order.
// ----------------------------------------------------------------------------
module sequence_reorder_buffer_test;
	import srb_pkg::*;

	localparam logic [2:0] ADDR_SEQ_WINDOW  = {IDX_SEQ_WINDOW, 2'b00};
	localparam logic [2:0] ADDR_UNMAPPED    = 3'd4;
	localparam int         WINDOW_RESET     = int'(SRB_WINDOW_RESET);
	localparam int         SETTLE_CYCLES    = 12;
	localparam int         WATCHDOG_LIMIT   = 5000;
	localparam int         IDLE_PERCENT     = 8;
	localparam int         HOLD_OFF_CYCLES  = 300;
	localparam int         PHASE_ITEMS      = 4;
	localparam int         PRESSURE_PACKETS = 4;
	localparam int         STEADY_PAIRS     = 12;

	// One input transfer
	typedef struct {
		logic        req;
		logic [7:0]  seq;
		logic [63:0] data;
		logic [3:0]  nbytes;
		logic        last;
	} request_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        req_type;
	logic [7:0]  seq;
	logic [63:0] data_word;
	logic [3:0]  in_bytes;
	logic        in_last;
	logic        out_valid;
	logic        out_stall;
	logic [1:0]  status;
	logic [63:0] out_word;
	logic [3:0]  out_bytes;
	logic        out_last;
	logic [7:0]  out_seq;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// Predicted buffer state
	logic [7:0]  accept_window;
	logic        slot_full [SRB_SLOTS];
	int          slot_len  [SRB_SLOTS];
	logic [63:0] slot_data [SRB_SLOTS][SRB_FRAME_WORDS];
	logic [7:0]  exp_seq_model;
	logic        push_open;
	logic        push_drop;
	int          push_slot_idx;
	int          push_pos;

	result_t pending_results[$];
	int      mismatch_total = 0;
	int      items_sent     = 0;
	int      hold_cycles    = 0;
	bit      steady         = 1'b0;

	sequence_reorder_buffer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.seq       (seq),
		.data_word (data_word),
		.in_bytes  (in_bytes),
		.in_last   (in_last),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.out_word  (out_word),
		.out_bytes (out_bytes),
		.out_last  (out_last),
		.out_seq   (out_seq),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	function automatic logic [63:0] keep_low_bytes(input logic [63:0] w, input int nb);
		if (nb >= 8)
			return w;
		return w & ((64'd1 << (8 * nb)) - 64'd1);
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	function automatic void reset_prediction();
		accept_window = 8'(WINDOW_RESET);
		for (int i = 0; i < SRB_SLOTS; i++)
			slot_full[i] = 1'b0;
		exp_seq_model = '0;
		push_open     = 1'b0;
		push_drop     = 1'b0;
		push_slot_idx = 0;
		push_pos      = 0;
	endfunction

	function automatic void queue_result(input status_t st, input logic [63:0] w,
			input logic [3:0] nb, input logic last, input logic [7:0] sq);
		result_t r;
		r.status = st;
		r.word   = w;
		r.bytes  = nb;
		r.last   = last;
		r.seq    = sq;
		pending_results.insert(pending_results.size(), r);
	endfunction

	// Work out the results that one accepted transfer causes
	function automatic void predict_transfer(input request_t it);
		logic [7:0] delta;
		int         d;
		int         w;
		int         nb;
		int         len;
		int         nwords;
		int         slot;
		if (it.req == REQ_PUSH) begin
			// first word fixes slot and drop decision for the whole packet
			if (!push_open) begin
				delta         = it.seq - exp_seq_model;
				d             = $signed(delta);
				w             = accept_window;
				push_drop     = (d < -w) || (d > w);
				push_slot_idx = it.seq % SRB_SLOTS;
				push_pos      = 0;
				push_open     = 1'b1;
				if (!push_drop)
					slot_full[push_slot_idx] = 1'b0;
			end
			if (!push_drop) begin
				nb = 8;
				if (it.last && it.nbytes >= 1 && it.nbytes <= 8)
					nb = it.nbytes;
				// store up to the frame limit, drop the rest
				if (push_pos < SRB_FRAME_WORDS) begin
					slot_data[push_slot_idx][push_pos] = keep_low_bytes(it.data, nb);
					push_pos++;
					if (it.last)
						slot_len[push_slot_idx] = (push_pos - 1) * 8 + nb;
				end else if (it.last) begin
					slot_len[push_slot_idx] = SRB_FRAME_WORDS * 8;
				end
				if (it.last)
					slot_full[push_slot_idx] = 1'b1;
			end
			if (it.last) begin
				queue_result(push_drop ? STAT_PUSH_DROP : STAT_PUSH_OK, '0, '0, 1'b1, it.seq);
				push_open = 1'b0;
				push_drop = 1'b0;
			end
		end else begin
			slot = exp_seq_model % SRB_SLOTS;
			if (!slot_full[slot]) begin
				queue_result(STAT_POP_EMPTY, '0, '0, 1'b1, exp_seq_model);
			end else begin
				len = slot_len[slot];
				if (len > SRB_FRAME_WORDS * 8)
					len = SRB_FRAME_WORDS * 8;
				if (len == 0)
					len = 1;
				nwords = (len + 7) / 8;
				// stream the packet, then free the slot and advance
				for (int i = 0; i < nwords; i++) begin
					nb = (i + 1 == nwords) ? len - i * 8 : 8;
					queue_result(STAT_POP_DATA, keep_low_bytes(slot_data[slot][i], nb),
						4'(nb), i + 1 == nwords, exp_seq_model);
				end
				slot_full[slot] = 1'b0;
				exp_seq_model   = exp_seq_model + 8'd1;
			end
		end
	endfunction

	function automatic void compare_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 'h%0h, got 'h%0h", name, want, got);
			mismatch_total++;
		end
	endfunction

	// Offer one transfer, hold it until accepted, then predict
	task automatic send_item(input request_t it);
		if (!steady) begin
			while ($urandom_range(99) < IDLE_PERCENT) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
		end
		in_valid  <= 1'b1;
		req_type  <= it.req;
		seq       <= it.seq;
		data_word <= it.data;
		in_bytes  <= it.nbytes;
		in_last   <= it.last;
		do @(posedge clk); while (in_stall !== 1'b0);
		items_sent++;
		predict_transfer(it);
	endtask

	task automatic push_word(input logic [7:0] sq, input logic [63:0] data,
			input logic [3:0] nbytes, input logic last);
		request_t it;
		it.req    = REQ_PUSH;
		it.seq    = sq;
		it.data   = data;
		it.nbytes = nbytes;
		it.last   = last;
		send_item(it);
	endtask

	// Pop with random content in the fields it ignores
	task automatic pop_request();
		request_t it;
		it.req    = REQ_POP;
		it.seq    = 8'($urandom);
		it.data   = random_word();
		it.nbytes = 4'($urandom);
		it.last   = 1'($urandom);
		send_item(it);
	endtask

	// Random-content packet; later words may carry a stray seq
	task automatic push_packet(input logic [7:0] first_seq, input int nwords, input bit mid_pops);
		request_t it;
		for (int i = 0; i < nwords; i++) begin
			it.req  = REQ_PUSH;
			it.seq  = (i > 0 && $urandom_range(7) == 0) ? 8'($urandom) : first_seq;
			it.data = random_word();
			it.last = (i == nwords - 1);
			if (!it.last)
				it.nbytes = 4'($urandom);
			else if ($urandom_range(5) == 0)
				it.nbytes = ($urandom_range(1) == 0) ? 4'd0 : 4'($urandom_range(9, 15));
			else
				it.nbytes = 4'($urandom_range(1, 8));
			send_item(it);
			if (mid_pops && !it.last && $urandom_range(9) == 0)
				pop_request();
		end
	endtask

	// Drop valid and wait until every predicted result has come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
		if (addr == ADDR_SEQ_WINDOW)
			accept_window = value[7:0];
	endtask

	task automatic check_window_readback();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= ADDR_SEQ_WINDOW;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		compare_field("seq_window", accept_window, prdata[7:0]);
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_window(input int value);
		wait_drained();
		write_register(ADDR_SEQ_WINDOW, 32'(value));
		check_window_readback();
	endtask

	task automatic test_reset_values();
		check_window_readback();
		pop_request();
	endtask

	// Extremes of the fields and each corner of push and pop
	task automatic test_directed();
		push_word(8'd0, '1, 4'd8, 1'b1);
		pop_request();
		// non-last byte count ignored, one byte on last
		push_word(8'd1, '0, 4'd5, 1'b0);
		push_word(8'd1, '1, 4'd1, 1'b1);
		pop_request();
		// zero and oversize byte counts on last count as eight
		push_word(8'd2, random_word(), 4'd0, 1'b1);
		pop_request();
		push_word(8'd3, random_word(), 4'd15, 1'b1);
		pop_request();
		// out_seq follows the last word
		push_word(8'd4, random_word(), 4'd8, 1'b0);
		push_word(8'hA5, random_word(), 4'd3, 1'b1);
		pop_request();
		// drop ahead of and behind the window
		push_word(8'd105, random_word(), 4'd8, 1'b0);
		push_word(8'd105, random_word(), 4'd8, 1'b1);
		pop_request();
		push_word(8'd161, random_word(), 4'd8, 1'b1);
		// accept behind expected across the wrap
		push_word(8'hFD, random_word(), 4'd6, 1'b1);
		// overwrite a held slot, pop in the middle of the push
		push_word(8'd5, random_word(), 4'd8, 1'b1);
		push_word(8'd21, random_word(), 4'd8, 1'b0);
		pop_request();
		push_word(8'd21, random_word(), 4'd2, 1'b1);
		pop_request();
	endtask

	// Exactly the frame limit, then one word past it
	task automatic test_frame_limit();
		push_packet(exp_seq_model, SRB_FRAME_WORDS, 1'b0);
		pop_request();
		push_packet(exp_seq_model, SRB_FRAME_WORDS + 1, 1'b0);
		pop_request();
	endtask

	task automatic test_window_limits();
		set_window(0);
		push_word(8'(exp_seq_model + 8'd1), random_word(), 4'd8, 1'b1);
		push_word(8'(exp_seq_model - 8'd1), random_word(), 4'd8, 1'b1);
		push_word(exp_seq_model, random_word(), 4'd7, 1'b1);
		pop_request();
		set_window(128);
		push_word(8'(exp_seq_model + 8'd128), random_word(), 4'd8, 1'b1);
		push_word(8'(exp_seq_model + 8'd127), random_word(), 4'd8, 1'b1);
		set_window(127);
		push_word(8'(exp_seq_model + 8'd128), random_word(), 4'd8, 1'b1);
		push_word(8'(exp_seq_model - 8'd127), random_word(), 4'd8, 1'b1);
		// a write outside the register map leaves the window alone
		wait_drained();
		write_register(ADDR_UNMAPPED, 32'd0);
		check_window_readback();
		set_window(1);
		push_word(8'(exp_seq_model + 8'd1), random_word(), 4'd8, 1'b1);
		push_word(8'(exp_seq_model + 8'd2), random_word(), 4'd8, 1'b1);
		push_word(8'(exp_seq_model - 8'd1), random_word(), 4'd8, 1'b1);
		pop_request();
		set_window(WINDOW_RESET);
	endtask

	// Hold the output off while the sender keeps streaming
	task automatic test_backpressure();
		logic [7:0] base;
		wait_drained();
		base        = exp_seq_model;
		steady      = 1'b1;
		hold_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < PRESSURE_PACKETS; i++)
			push_packet(8'(base + 8'(i)), 2, 1'b0);
		repeat (PRESSURE_PACKETS) pop_request();
		wait_drained();
		steady = 1'b0;
	endtask

	// Mostly packets near the expected sequence, some pops, some strays
	task automatic test_random();
		int windows[5];
		int start;
		int pick;
		int offset;
		int nwords;
		windows = '{64, 0, 128, 5, 127};
		foreach (windows[p]) begin
			set_window(windows[p]);
			start = items_sent;
			while (items_sent - start < PHASE_ITEMS) begin
				pick = $urandom_range(99);
				if (pick < 55) begin
					offset = $urandom_range(15);
					offset = offset - 4;
					nwords = ($urandom_range(19) == 0) ? $urandom_range(30, 36)
						: $urandom_range(1, 4);
					push_packet(8'(int'(exp_seq_model) + offset), nwords, 1'b1);
				end else if (pick < 90) begin
					pop_request();
				end else if (pick < 97) begin
					push_packet(8'($urandom), $urandom_range(1, 3), 1'b1);
				end else begin
					// pause the sender until the output is empty
					wait_drained();
				end
			end
		end
		set_window(WINDOW_RESET);
	endtask

	// Push and pop pairs back to back with no idling on either side
	task automatic test_steady_stream();
		steady = 1'b1;
		repeat (STEADY_PAIRS) begin
			push_word(exp_seq_model, random_word(), 4'($urandom_range(1, 8)), 1'b1);
			pop_request();
		end
		wait_drained();
		steady = 1'b0;
	endtask

	// Check each output transfer against the oldest prediction
	always @(posedge clk) begin
		result_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				$error("result with none expected: status %0d out_seq %0d", status, out_seq);
				mismatch_total++;
			end else begin
				want = pending_results.pop_front();
				compare_field("status", want.status, status);
				compare_field("out_word", want.word, out_word);
				compare_field("out_bytes", want.bytes, out_bytes);
				compare_field("out_last", want.last, out_last);
				compare_field("out_seq", want.seq, out_seq);
			end
		end
	end

	// Receiver stall: long hold-off on request, otherwise random
	initial begin
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_cycles > 0) begin
				out_stall <= 1'b1;
				hold_cycles--;
			end else if (steady) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(99) < IDLE_PERCENT);
			end
		end
	end

	// Stop the run when no transfer moves for too long
	initial begin
		int idle_run;
		idle_run = 0;
		while (idle_run < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0) ||
					(psel === 1'b1 && penable === 1'b1))
				idle_run = 0;
			else
				idle_run++;
		end
		$display("sequence_reorder_buffer_test: FAIL");
		$finish;
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		req_type  = REQ_PUSH;
		seq       = '0;
		data_word = '0;
		in_bytes  = '0;
		in_last   = 1'b0;
		psel      = 1'b0;
		penable   = 1'b0;
		pwrite    = 1'b0;
		paddr     = ADDR_SEQ_WINDOW;
		pwdata    = '0;
		reset_prediction();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_directed();
		test_frame_limit();
		test_window_limits();
		test_backpressure();
		test_random();
		test_steady_stream();
		wait_drained();
		if (mismatch_total == 0)
			$display("sequence_reorder_buffer_test: PASS");
		else
			$display("sequence_reorder_buffer_test: FAIL");
		$finish;
	end

endmodule

/* sim.f */
+incdir+sv
sv/srb_pkg.sv
sv/srb_ram.sv
sv/srb_out_buf.sv
sv/sequence_reorder_buffer.sv
tb/sequence_reorder_buffer_test.sv
